>>> design/dtlv_pkg.sv
// shared types and constants for the delimited tlv frame parser
// no dependencies; used by every module in this folder
package dtlv_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned OFFSET_W    = 16;
	localparam int unsigned SLOT_OUT_W  = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = CFG_INDEX_W'(1);

	localparam logic [7:0] START_MARKER_RST = 8'd170;
	localparam logic [7:0] END_MARKER_RST   = 8'd85;

	localparam logic KIND_PAYLOAD  = 1'b0;
	localparam logic KIND_COMPLETE = 1'b1;

	// byte held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} in_stage_t;

	// one result item
	typedef struct packed {
		logic                  kind;
		logic [7:0]            event_type;
		logic [7:0]            payload_byte;
		logic [OFFSET_W-1:0]   byte_offset;
		logic [OFFSET_W-1:0]   frame_length;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic                  final_byte;
	} result_t;

endpackage

>>> design/delimited_tlv_frame_parser.sv
// delimited tlv frame parser: one received byte per cycle while not stalled, one result at most per byte
// path: a byte passes the input register, then its result is loaded into the result register
// throughput: one byte per cycle; a byte waits only when its result finds the result register full and stalled
// reset: asynchronous, active low; parser waits for a start marker, slot 0, markers 170 and 85
// depends on dtlv_pkg, dtlv_in_stage, dtlv_parse
module delimited_tlv_frame_parser #(
	parameter int unsigned SLOT_COUNT = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dtlv_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [7:0]                          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          data_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                kind,
	output logic [7:0]                          event_type,
	output logic [7:0]                          payload_byte,
	output logic [dtlv_pkg::OFFSET_W-1:0]       byte_offset,
	output logic [dtlv_pkg::OFFSET_W-1:0]       frame_length,
	output logic [dtlv_pkg::SLOT_OUT_W-1:0]     slot_index,
	output logic                                final_byte
);

	logic [7:0]          start_marker_q;
	logic [7:0]          end_marker_q;
	logic                advance;
	dtlv_pkg::in_stage_t stage;
	dtlv_pkg::result_t   result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= dtlv_pkg::START_MARKER_RST;
			end_marker_q   <= dtlv_pkg::END_MARKER_RST;
		end else if (cfg_we) begin
			// unknown register index is ignored
			case (cfg_index)
				dtlv_pkg::REG_START_MARKER: start_marker_q <= cfg_data;
				dtlv_pkg::REG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	dtlv_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.advance   (advance),
		.stage     (stage)
	);

	dtlv_parse #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage        (stage),
		.advance      (advance),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result       (result)
	);

	assign kind         = result.kind;
	assign event_type   = result.event_type;
	assign payload_byte = result.payload_byte;
	assign byte_offset  = result.byte_offset;
	assign frame_length = result.frame_length;
	assign slot_index   = result.slot_index;
	assign final_byte   = result.final_byte;

endmodule

>>> design/dtlv_in_stage.sv
// input register of the frame parser: holds one received byte
// depends on dtlv_pkg
module dtlv_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 advance,
	output dtlv_pkg::in_stage_t  stage
);

	logic       valid_s1;
	logic [7:0] data_s1;

	// held byte leaves when the parser consumes it
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = data_s1;

endmodule

>>> design/dtlv_parse.sv
// frame state machine and result register of the frame parser
// depends on dtlv_pkg
module dtlv_parse #(
	parameter int unsigned SLOT_COUNT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dtlv_pkg::in_stage_t stage,
	output logic                advance,
	input  logic [7:0]          start_marker,
	input  logic [7:0]          end_marker,
	output logic                out_valid,
	input  logic                out_stall,
	output dtlv_pkg::result_t   result
);

	localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		PH_WAIT_START,
		PH_EVENT,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_WAIT_END
	} phase_t;

	phase_t                          phase_q;
	logic [7:0]                      event_q;
	logic [dtlv_pkg::OFFSET_W-1:0]   length_q;
	logic [dtlv_pkg::OFFSET_W-1:0]   seen_q;
	logic [SLOT_W-1:0]               slot_q;
	logic                            out_valid_q;
	dtlv_pkg::result_t               result_s2;

	logic                            has_result;
	logic                            fin;
	logic [dtlv_pkg::OFFSET_W:0]     seen_inc;
	logic [dtlv_pkg::OFFSET_W-1:0]   new_length;
	logic [SLOT_W+dtlv_pkg::SLOT_OUT_W-1:0] slot_ext;
	dtlv_pkg::result_t               res_d;

	assign seen_inc   = {1'b0, seen_q} + 17'd1;
	assign fin        = seen_inc >= {1'b0, length_q};
	assign new_length = {stage.data, length_q[7:0]};
	assign slot_ext   = {{dtlv_pkg::SLOT_OUT_W{1'b0}}, slot_q};

	always_comb begin
		has_result = 1'b0;
		case (phase_q)
			PH_PAYLOAD:  has_result = 1'b1;
			PH_WAIT_END: has_result = (stage.data == end_marker);
			default:     has_result = 1'b0;
		endcase
	end

	// a byte with no result never waits on the output side
	assign advance = stage.valid && (!has_result || !out_valid_q || !out_stall);

	always_comb begin
		res_d.kind         = (phase_q == PH_PAYLOAD) ? dtlv_pkg::KIND_PAYLOAD
		                                             : dtlv_pkg::KIND_COMPLETE;
		res_d.event_type   = event_q;
		res_d.frame_length = length_q;
		res_d.slot_index   = slot_ext[dtlv_pkg::SLOT_OUT_W-1:0];
		if (phase_q == PH_PAYLOAD) begin
			res_d.payload_byte = stage.data;
			res_d.byte_offset  = seen_q;
			res_d.final_byte   = fin;
		end else begin
			res_d.payload_byte = 8'd0;
			res_d.byte_offset  = '0;
			res_d.final_byte   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT_START;
			event_q     <= 8'd0;
			length_q    <= '0;
			seen_q      <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && has_result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				case (phase_q)
					PH_EVENT: begin
						event_q <= stage.data;
						phase_q <= PH_LEN_LO;
					end
					PH_LEN_LO: begin
						length_q <= {8'd0, stage.data};
						phase_q  <= PH_LEN_HI;
					end
					PH_LEN_HI: begin
						length_q <= new_length;
						seen_q   <= '0;
						phase_q  <= (new_length == '0) ? PH_WAIT_END : PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						if (fin) begin
							seen_q  <= '0;
							phase_q <= PH_WAIT_END;
						end else begin
							seen_q <= seen_inc[dtlv_pkg::OFFSET_W-1:0];
						end
					end
					PH_WAIT_END: begin
						if (has_result) begin
							slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
							phase_q <= PH_WAIT_START;
						end
					end
					default: begin
						if (stage.data == start_marker) begin
							event_q  <= 8'd0;
							length_q <= '0;
							seen_q   <= '0;
							phase_q  <= PH_EVENT;
						end else begin
							phase_q <= PH_WAIT_START;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_s2 <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_s2;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// self-checking bench for delimited_tlv_frame_parser: frames, noise and broken frames
// are driven through valid/stall, results are checked against a parser model kept here
// depends on dtlv_pkg and delimited_tlv_frame_parser
module tb;

	localparam int unsigned SLOT_COUNT  = 64;
	localparam int          DIR_ROWS    = 27;
	localparam int          WDOG_LIMIT  = 4000;
	localparam int          LONG_HOLD   = 400;
	localparam int          SETTLE_CYC  = 6;
	localparam logic [dtlv_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = dtlv_pkg::CFG_INDEX_W'(2);
	localparam logic [dtlv_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = dtlv_pkg::CFG_INDEX_W'(3);
	localparam dtlv_pkg::result_t NO_RES = '0;

	typedef enum logic [2:0] {
		PH_WAIT_START,
		PH_EVENT,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_WAIT_END
	} parse_phase_t;

	typedef struct {
		logic [7:0]        b;
		bit                typed;
		bit                has_res;
		dtlv_pkg::result_t res;
	} stim_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [dtlv_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]                       cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [7:0]                       data_byte = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             kind;
	logic [7:0]                       event_type;
	logic [7:0]                       payload_byte;
	logic [dtlv_pkg::OFFSET_W-1:0]    byte_offset;
	logic [dtlv_pkg::OFFSET_W-1:0]    frame_length;
	logic [dtlv_pkg::SLOT_OUT_W-1:0]  slot_index;
	logic                             final_byte;

	// parser model state
	parse_phase_t  pm_phase = PH_WAIT_START;
	logic [7:0]    pm_event = '0;
	logic [15:0]   pm_length = '0;
	logic [15:0]   pm_seen = '0;
	int unsigned   pm_slot = 0;
	logic [7:0]    start_mark = dtlv_pkg::START_MARKER_RST;
	logic [7:0]    end_mark = dtlv_pkg::END_MARKER_RST;

	dtlv_pkg::result_t pending_results [$];
	stim_row_t         dir_tab [DIR_ROWS];
	dtlv_pkg::result_t got_res;
	dtlv_pkg::result_t want_res;
	int        mism_count = 0;
	int        frame_bytes_sent = 0;
	int        frames_closed = 0;
	int        burst_left = 8;
	bit        steady = 1'b0;
	int        quiet_cycles = 0;
	int        rx_cycle = 0;
	int        rx_mode = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;

	delimited_tlv_frame_parser #(
		.SLOT_COUNT(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.event_type(event_type),
		.payload_byte(payload_byte),
		.byte_offset(byte_offset),
		.frame_length(frame_length),
		.slot_index(slot_index),
		.final_byte(final_byte)
	);

	always #5 clk = ~clk;

	function automatic dtlv_pkg::result_t mk_res(logic k, logic [7:0] ev, logic [7:0] pay,
			logic [15:0] off, logic [15:0] len, logic [5:0] slot, logic fin);
		dtlv_pkg::result_t r;
		r = '{k, ev, pay, off, len, slot, fin};
		return r;
	endfunction

	// advance the parser model by one byte; returns 1 when a result comes out
	function automatic bit parse_byte(input logic [7:0] b, output dtlv_pkg::result_t r);
		bit hit;
		bit last;
		hit = 1'b0;
		r = NO_RES;
		case (pm_phase)
			PH_EVENT: begin
				pm_event = b;
				pm_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				pm_length = {8'h00, b};
				pm_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				pm_length = {b, pm_length[7:0]};
				pm_seen = '0;
				pm_phase = (pm_length == 16'd0) ? PH_WAIT_END : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				last = ({1'b0, pm_seen} + 17'd1 >= {1'b0, pm_length});
				r = mk_res(dtlv_pkg::KIND_PAYLOAD, pm_event, b, pm_seen, pm_length,
					pm_slot[5:0], last);
				hit = 1'b1;
				if (last) begin
					pm_seen = '0;
					pm_phase = PH_WAIT_END;
				end else begin
					pm_seen = pm_seen + 16'd1;
				end
			end
			PH_WAIT_END: begin
				if (b == end_mark) begin
					r = mk_res(dtlv_pkg::KIND_COMPLETE, pm_event, 8'h00, 16'd0, pm_length,
						pm_slot[5:0], 1'b0);
					hit = 1'b1;
					pm_slot = (pm_slot + 1 >= SLOT_COUNT) ? 0 : pm_slot + 1;
					frames_closed++;
					pm_phase = PH_WAIT_START;
				end
			end
			default: begin
				pm_phase = PH_WAIT_START;
				if (b == start_mark) begin
					pm_event = '0;
					pm_length = '0;
					pm_seen = '0;
					pm_phase = PH_EVENT;
				end
			end
		endcase
		return hit;
	endfunction

	// offer one byte, hold it until taken, then log what the parser should emit
	task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1,
			input bit typed = 1'b0, input bit typed_has = 1'b0,
			input dtlv_pkg::result_t typed_res = NO_RES);
		dtlv_pkg::result_t r;
		bit hit;
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		hit = parse_byte(b, r);
		if (typed) begin
			if (typed_has)
				pending_results.push_back(typed_res);
		end else if (hit) begin
			pending_results.push_back(r);
		end
		if (counted)
			frame_bytes_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 60);
			if (!steady) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	// stop offering and let every outstanding request drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [dtlv_pkg::CFG_INDEX_W-1:0] idx,
			input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == dtlv_pkg::REG_START_MARKER)
			start_mark = val;
		else if (idx == dtlv_pkg::REG_END_MARKER)
			end_mark = val;
		@(posedge clk);
	endtask

	task automatic send_noise(input logic [7:0] avoid);
		logic [7:0] nb;
		repeat ($urandom_range(1, 3)) begin
			do nb = 8'($urandom); while (nb == avoid);
			send_byte(nb, 1'b0);
		end
	endtask

	// mostly well-formed frames, with raw bursts, cut payloads and lost end markers mixed in
	task automatic random_frame();
		int sel;
		int len;
		int cut;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			repeat ($urandom_range(3, 12)) send_byte(8'($urandom));
			return;
		end
		if ($urandom_range(0, 9) < 3)
			send_noise(start_mark);
		len = $urandom_range(0, 99);
		if (len < 10)
			len = 0;
		else if (len < 80)
			len = $urandom_range(1, 6);
		else if (len < 95)
			len = $urandom_range(7, 40);
		else
			len = $urandom_range(41, 300);
		send_byte(start_mark);
		send_byte(8'($urandom));
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		cut = (sel < 14) ? $urandom_range(0, len) : len;
		repeat (cut) send_byte(8'($urandom));
		if (sel < 18)
			return;
		if ($urandom_range(0, 9) < 2)
			send_noise(end_mark);
		send_byte(end_mark);
	endtask

	task automatic random_phase(input int target, input int min_closed);
		int base;
		base = frame_bytes_sent;
		while (frame_bytes_sent - base < target || frames_closed < min_closed)
			random_frame();
	endtask

	// short frames with no payload until the slot index has wrapped
	task automatic close_frames(input int min_closed);
		while (frames_closed < min_closed) begin
			send_byte(start_mark);
			send_byte(8'($urandom));
			send_byte(8'h00);
			send_byte(8'h00);
			send_byte(end_mark);
		end
	endtask

	task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			mism_count++;
			if (mism_count <= 40)
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_res = '{kind, event_type, payload_byte, byte_offset, frame_length,
				slot_index, final_byte};
			if (pending_results.size() == 0) begin
				mism_count++;
				if (mism_count <= 40)
					$display("%0t: no result expected, actual %h", $time, got_res);
			end else begin
				want_res = pending_results.pop_front();
				cmp_field("kind", 16'(want_res.kind), 16'(got_res.kind));
				cmp_field("event_type", 16'(want_res.event_type), 16'(got_res.event_type));
				cmp_field("payload_byte", 16'(want_res.payload_byte),
					16'(got_res.payload_byte));
				cmp_field("byte_offset", want_res.byte_offset, got_res.byte_offset);
				cmp_field("frame_length", want_res.frame_length, got_res.frame_length);
				cmp_field("slot_index", 16'(want_res.slot_index), 16'(got_res.slot_index));
				cmp_field("final_byte", 16'(want_res.final_byte), 16'(got_res.final_byte));
			end
		end
	end

	// receiver stall pattern, with one long hold-off once traffic is going
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && frame_bytes_sent >= 150) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			if (rx_cycle % 97 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 7) == 0);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("delimited_tlv_frame_parser: mismatch");
			$finish;
		end
	end

	initial begin
		logic [7:0] mark;
		dir_tab = '{
			'{8'h00, 1'b1, 1'b0, NO_RES},
			'{8'hFF, 1'b1, 1'b0, NO_RES},
			'{8'hAA, 1'b1, 1'b0, NO_RES},
			'{8'h00, 1'b1, 1'b0, NO_RES},
			'{8'h01, 1'b1, 1'b0, NO_RES},
			'{8'h00, 1'b1, 1'b0, NO_RES},
			'{8'hFF, 1'b1, 1'b1,
				mk_res(dtlv_pkg::KIND_PAYLOAD, 8'h00, 8'hFF, 16'd0, 16'd1, 6'd0, 1'b1)},
			'{8'hAA, 1'b1, 1'b0, NO_RES},
			'{8'h55, 1'b1, 1'b1,
				mk_res(dtlv_pkg::KIND_COMPLETE, 8'h00, 8'h00, 16'd0, 16'd1, 6'd0, 1'b0)},
			'{8'hAA, 1'b1, 1'b0, NO_RES},
			'{8'hFF, 1'b1, 1'b0, NO_RES},
			'{8'h00, 1'b1, 1'b0, NO_RES},
			'{8'h00, 1'b1, 1'b0, NO_RES},
			'{8'h55, 1'b1, 1'b1,
				mk_res(dtlv_pkg::KIND_COMPLETE, 8'hFF, 8'h00, 16'd0, 16'd0, 6'd1, 1'b0)},
			'{8'hAA, 1'b0, 1'b0, NO_RES},
			'{8'h5A, 1'b0, 1'b0, NO_RES},
			'{8'h02, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h80, 1'b0, 1'b0, NO_RES},
			'{8'h7F, 1'b0, 1'b0, NO_RES},
			'{8'h55, 1'b0, 1'b0, NO_RES},
			'{8'hAA, 1'b0, 1'b0, NO_RES},
			'{8'hAA, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h55, 1'b0, 1'b0, NO_RES},
			'{8'h55, 1'b0, 1'b0, NO_RES}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(dir_tab[i].b, 1'b1, dir_tab[i].typed, dir_tab[i].has_res,
				dir_tab[i].res);
		settle();

		// writes past the register list must leave both markers alone
		cfg_write(REG_SPARE_LO, 8'($urandom));
		cfg_write(REG_SPARE_HI, 8'($urandom));
		random_phase(40, 0);
		settle();

		cfg_write(dtlv_pkg::REG_START_MARKER, 8'h00);
		cfg_write(dtlv_pkg::REG_END_MARKER, 8'hFF);
		random_phase(40, 0);
		settle();

		cfg_write(dtlv_pkg::REG_START_MARKER, 8'hFF);
		cfg_write(dtlv_pkg::REG_END_MARKER, 8'h00);
		random_phase(40, 0);
		settle();

		// same byte opens and closes a frame
		mark = 8'($urandom);
		cfg_write(dtlv_pkg::REG_START_MARKER, mark);
		cfg_write(dtlv_pkg::REG_END_MARKER, mark);
		random_phase(30, 0);
		// one frame sent back to back
		steady = 1'b1;
		send_byte(start_mark);
		send_byte(8'($urandom));
		send_byte(8'd24);
		send_byte(8'h00);
		repeat (24) send_byte(8'($urandom));
		send_byte(end_mark);
		steady = 1'b0;
		settle();

		cfg_write(dtlv_pkg::REG_START_MARKER, 8'($urandom));
		cfg_write(dtlv_pkg::REG_END_MARKER, 8'($urandom));
		close_frames(SLOT_COUNT + 2);
		settle();

		if (mism_count == 0)
			$display("delimited_tlv_frame_parser: match");
		else
			$display("delimited_tlv_frame_parser: mismatch");
		$finish;
	end

endmodule
